// File: sv/fpdf_pkg.sv
// ---------------------------------------------------------------------------
// Fixed-point decimal formatter package
// Character codes, range limits, reciprocal constants and pipeline types
// shared by the formatter.
// ---------------------------------------------------------------------------
package fpdf_pkg;

   // Format selection codes.
   localparam logic FUNC_MILLI = 1'b0;   // signed decimal, 0.001 resolution
   localparam logic FUNC_BIN8  = 1'b1;   // unsigned binary, 1/256 resolution

   // Field widths.
   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 7;
   localparam int LEN_W   = 3;
   localparam int NUM_W   = 20;          // widest registered value: scaled value t
   localparam int H_W     = 17;          // hundredths (or magnitude), up to 99999
   localparam int HI_W    = 7;           // h / 1000, up to 99
   localparam int LO_W    = 10;          // h % 1000
   localparam int DIG_W   = 4;

   // ASCII codes.
   localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_STAR  = 7'h2A;
   localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

   // String lengths.
   localparam logic [LEN_W-1:0] LEN_SHORT = 3'd5;
   localparam logic [LEN_W-1:0] LEN_FULL  = 3'd6;

   // Range limits.
   localparam logic [VALUE_W-1:0] MILLI_MAX = 32'd9999;
   localparam logic [VALUE_W-1:0] BIN8_MAX  = 32'd255999;
   localparam logic [H_W-1:0]     H_MAX     = 17'd99999;

   // Scale factor for 1/256 to 0.001 units.
   localparam logic [27:0] SCALE_1000 = 28'd1000;

   // Reciprocals: x / 10 = (x * RECIP10) >> 23 for x < 2^20, and so on.
   localparam logic [NUM_W-1:0] RECIP10      = 20'd838861;
   localparam int               RECIP10_SH   = 23;
   localparam logic [17:0]      RECIP1000    = 18'd134218;
   localparam int               RECIP1000_SH = 27;
   localparam logic [7:0]       RECIP10_S    = 8'd205;   // shift 11, x < 1024
   localparam logic [5:0]       RECIP100_S   = 6'd41;    // shift 12, x < 1024

   // Side-band control that travels with each beat through the pipeline.
   typedef struct packed {
      logic valid;
      logic func;
      logic ovf;
      logic neg;
   } ctl_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
      digit_char = CH_ZERO + {3'b000, d};
   endfunction

endpackage

// File: sv/fixed_point_decimal_formatter.sv
// ---------------------------------------------------------------------------
// Fixed-point decimal formatter
// Turns a 32-bit fixed-point word into a six-character ASCII decimal string
// and its length, in one of two formats, through a nine-stage pipeline.
// ---------------------------------------------------------------------------
//
//   Channel   Ports                                   Direction  Handshake
//   request   start, busy, req_func, req_value        in         start & !busy
//   response  rsp_strobe, rsp_char_a..f, rsp_length   out        rsp_strobe
//
// One beat can enter on every clock cycle. Each beat leaves on the response
// ports once it has passed through every stage, for exactly one cycle under
// rsp_strobe. The latency is set by the chain of reciprocal multiplications
// (by 1/10 for rounding, by 1/1000, 1/100 and 1/10 for the digits), each
// with a register after it. The receiver cannot stall, so nothing in the
// pipeline ever stops and busy is held low. Reset is synchronous and clears
// the control registers only; beats in flight at reset are dropped.
//
module fixed_point_decimal_formatter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [fpdf_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_strobe,
   output logic [fpdf_pkg::CHAR_W-1:0]      rsp_char_a,
   output logic [fpdf_pkg::CHAR_W-1:0]      rsp_char_b,
   output logic [fpdf_pkg::CHAR_W-1:0]      rsp_char_c,
   output logic [fpdf_pkg::CHAR_W-1:0]      rsp_char_d,
   output logic [fpdf_pkg::CHAR_W-1:0]      rsp_char_e,
   output logic [fpdf_pkg::CHAR_W-1:0]      rsp_char_f,
   output logic [fpdf_pkg::LEN_W-1:0]       rsp_length
);

   // Control side-band for each stage.
   fpdf_pkg::ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   fpdf_pkg::ctl_type s5_ctl_ff, s6_ctl_ff, s7_ctl_ff, s8_ctl_ff;
   fpdf_pkg::ctl_type s1_ctl_in;
   logic              rsp_valid_ff;

   // Stage 1: range check, magnitude, and scaling by 1000/256.
   logic [fpdf_pkg::VALUE_W-1:0] mag_in;
   logic [27:0]                  scaled_in;
   logic [fpdf_pkg::NUM_W-1:0]   s1_num_in, s1_num_ff;

   // Stage 2: t / 10 by reciprocal.
   logic [39:0]                  q10_prod;
   logic [fpdf_pkg::NUM_W-1:0]   s2_num_ff;
   logic [fpdf_pkg::H_W-1:0]     s2_q10_in, s2_q10_ff;

   // Stage 3: rounding to hundredths and clamping.
   logic [fpdf_pkg::NUM_W-1:0]   q10x10;
   logic [fpdf_pkg::NUM_W-1:0]   t_rem;
   logic [fpdf_pkg::H_W:0]       h_round;
   logic [fpdf_pkg::H_W-1:0]     s3_h_in, s3_h_ff;

   // Stage 4: h / 1000 by reciprocal.
   logic [34:0]                  q1000_prod;
   logic [fpdf_pkg::H_W-1:0]     s4_h_ff;
   logic [fpdf_pkg::HI_W-1:0]    s4_hi_in, s4_hi_ff;

   // Stage 5: h % 1000.
   logic [fpdf_pkg::H_W-1:0]     lo_diff;
   logic [fpdf_pkg::HI_W-1:0]    s5_hi_ff;
   logic [fpdf_pkg::LO_W-1:0]    s5_lo_in, s5_lo_ff;

   // Stage 6: hi / 10 and lo / 100 by reciprocal.
   logic [14:0]                  hi_t_prod;
   logic [15:0]                  lo_h_prod;
   logic [fpdf_pkg::HI_W-1:0]    s6_hi_ff;
   logic [fpdf_pkg::LO_W-1:0]    s6_lo_ff;
   logic [fpdf_pkg::DIG_W-1:0]   s6_hi_t_in, s6_hi_t_ff;
   logic [fpdf_pkg::DIG_W-1:0]   s6_lo_h_in, s6_lo_h_ff;

   // Stage 7: the upper three digits and the remainder below one hundred.
   logic [fpdf_pkg::HI_W-1:0]    d3_diff;
   logic [fpdf_pkg::LO_W-1:0]    rem_diff;
   logic [fpdf_pkg::DIG_W-1:0]   s7_d4_ff, s7_d3_in, s7_d3_ff, s7_d2_ff;
   logic [6:0]                   s7_rem_in, s7_rem_ff;

   // Stage 8: the last two digits.
   logic [14:0]                  d1_prod;
   logic [6:0]                   d0_diff;
   logic [fpdf_pkg::DIG_W-1:0]   s8_d4_ff, s8_d3_ff, s8_d2_ff;
   logic [fpdf_pkg::DIG_W-1:0]   s8_d1_in, s8_d1_ff, s8_d0_in, s8_d0_ff;

   // Output stage.
   logic [fpdf_pkg::CHAR_W-1:0]  char_a_in, char_b_in, char_c_in;
   logic [fpdf_pkg::CHAR_W-1:0]  char_d_in, char_e_in, char_f_in;
   logic [fpdf_pkg::LEN_W-1:0]   length_in;
   logic [fpdf_pkg::CHAR_W-1:0]  rsp_char_a_ff, rsp_char_b_ff, rsp_char_c_ff;
   logic [fpdf_pkg::CHAR_W-1:0]  rsp_char_d_ff, rsp_char_e_ff, rsp_char_f_ff;
   logic [fpdf_pkg::LEN_W-1:0]   rsp_length_ff;

   // The pipeline never stops, so a new beat is always welcome.
   assign busy = 1'b0;

   // ---------------------------------------------------------------- stage 1
   // Mode 0 works on the magnitude, which is at most 9999 when in range.
   // Mode 1 scales the raw value to thousandths: t = raw * 1000 / 256, which
   // fits in twenty bits whenever raw is in range.
   always_comb begin
      mag_in          = req_value[31] ? (32'd0 - req_value) : req_value;
      scaled_in       = 28'(req_value[17:0]) * fpdf_pkg::SCALE_1000;
      s1_ctl_in.valid = start & ~busy;
      s1_ctl_in.func  = req_func;
      s1_ctl_in.neg   = req_value[31];
      if (req_func == fpdf_pkg::FUNC_MILLI) begin
         s1_ctl_in.ovf = (mag_in > fpdf_pkg::MILLI_MAX);
         s1_num_in     = {6'd0, mag_in[13:0]};
      end else begin
         s1_ctl_in.ovf = (req_value > fpdf_pkg::BIN8_MAX);
         s1_num_in     = scaled_in[27:8];
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Exact t / 10 for any twenty-bit t.
   always_comb begin
      q10_prod  = 40'(s1_num_ff) * 40'(fpdf_pkg::RECIP10);
      s2_q10_in = q10_prod[fpdf_pkg::RECIP10_SH +: fpdf_pkg::H_W];
   end

   // ---------------------------------------------------------------- stage 3
   // Round half up to hundredths; a carry past 999.99 clamps rather than
   // wrapping. In mode 0 the magnitude passes straight on.
   always_comb begin
      q10x10  = {s2_q10_ff, 3'b000} + {2'b00, s2_q10_ff, 1'b0};
      t_rem   = s2_num_ff - q10x10;
      h_round = {1'b0, s2_q10_ff} + {{fpdf_pkg::H_W{1'b0}}, (t_rem[3:0] >= 4'd5)};
      if (s2_ctl_ff.func == fpdf_pkg::FUNC_MILLI) begin
         s3_h_in = s2_num_ff[fpdf_pkg::H_W-1:0];
      end else if (h_round > {1'b0, fpdf_pkg::H_MAX}) begin
         s3_h_in = fpdf_pkg::H_MAX;
      end else begin
         s3_h_in = h_round[fpdf_pkg::H_W-1:0];
      end
   end

   // ---------------------------------------------------------------- stage 4
   // Split h into thousands and the rest; h never exceeds 99999 here.
   always_comb begin
      q1000_prod = 35'(s3_h_ff) * 35'(fpdf_pkg::RECIP1000);
      s4_hi_in   = q1000_prod[fpdf_pkg::RECIP1000_SH +: fpdf_pkg::HI_W];
   end

   // ---------------------------------------------------------------- stage 5
   always_comb begin
      lo_diff  = s4_h_ff - (17'(s4_hi_ff) * 17'd1000);
      s5_lo_in = lo_diff[fpdf_pkg::LO_W-1:0];
   end

   // ---------------------------------------------------------------- stage 6
   always_comb begin
      hi_t_prod  = 15'(s5_hi_ff) * 15'(fpdf_pkg::RECIP10_S);
      lo_h_prod  = 16'(s5_lo_ff) * 16'(fpdf_pkg::RECIP100_S);
      s6_hi_t_in = hi_t_prod[14:11];
      s6_lo_h_in = lo_h_prod[15:12];
   end

   // ---------------------------------------------------------------- stage 7
   always_comb begin
      d3_diff   = s6_hi_ff - (7'(s6_hi_t_ff) * 7'd10);
      rem_diff  = s6_lo_ff - (10'(s6_lo_h_ff) * 10'd100);
      s7_d3_in  = d3_diff[fpdf_pkg::DIG_W-1:0];
      s7_rem_in = rem_diff[6:0];
   end

   // ---------------------------------------------------------------- stage 8
   always_comb begin
      d1_prod  = 15'(s7_rem_ff) * 15'(fpdf_pkg::RECIP10_S);
      s8_d1_in = d1_prod[14:11];
      d0_diff  = s7_rem_ff - (7'(s8_d1_in) * 7'd10);
      s8_d0_in = d0_diff[fpdf_pkg::DIG_W-1:0];
   end

   // ----------------------------------------------------------- output stage
   // Mode 0 prints the sign, one integer digit, a point and three decimals.
   // Mode 1 prints three integer places with leading blanks, a point and two
   // decimals. An out-of-range value prints stars around the point instead.
   always_comb begin
      length_in = fpdf_pkg::LEN_FULL;
      char_f_in = fpdf_pkg::CH_NUL;
      if (s8_ctl_ff.func == fpdf_pkg::FUNC_MILLI) begin
         if (s8_ctl_ff.ovf) begin
            char_a_in = fpdf_pkg::CH_STAR;
            char_b_in = fpdf_pkg::CH_POINT;
            char_c_in = fpdf_pkg::CH_STAR;
            char_d_in = fpdf_pkg::CH_STAR;
            char_e_in = fpdf_pkg::CH_STAR;
            length_in = fpdf_pkg::LEN_SHORT;
         end else begin
            char_a_in = s8_ctl_ff.neg ? fpdf_pkg::CH_MINUS : fpdf_pkg::CH_SPACE;
            char_b_in = fpdf_pkg::digit_char(s8_d3_ff);
            char_c_in = fpdf_pkg::CH_POINT;
            char_d_in = fpdf_pkg::digit_char(s8_d2_ff);
            char_e_in = fpdf_pkg::digit_char(s8_d1_ff);
            char_f_in = fpdf_pkg::digit_char(s8_d0_ff);
         end
      end else begin
         if (s8_ctl_ff.ovf) begin
            char_a_in = fpdf_pkg::CH_STAR;
            char_b_in = fpdf_pkg::CH_STAR;
            char_c_in = fpdf_pkg::CH_STAR;
            char_d_in = fpdf_pkg::CH_POINT;
            char_e_in = fpdf_pkg::CH_STAR;
            char_f_in = fpdf_pkg::CH_STAR;
         end else begin
            char_a_in = (s8_d4_ff == 4'd0) ? fpdf_pkg::CH_SPACE
                                           : fpdf_pkg::digit_char(s8_d4_ff);
            char_b_in = (s8_d4_ff == 4'd0 && s8_d3_ff == 4'd0)
                        ? fpdf_pkg::CH_SPACE : fpdf_pkg::digit_char(s8_d3_ff);
            char_c_in = fpdf_pkg::digit_char(s8_d2_ff);
            char_d_in = fpdf_pkg::CH_POINT;
            char_e_in = fpdf_pkg::digit_char(s8_d1_ff);
            char_f_in = fpdf_pkg::digit_char(s8_d0_ff);
         end
      end
   end

   // Control registers: valid bits and the side-band that goes with them.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff    <= '0;
         s2_ctl_ff    <= '0;
         s3_ctl_ff    <= '0;
         s4_ctl_ff    <= '0;
         s5_ctl_ff    <= '0;
         s6_ctl_ff    <= '0;
         s7_ctl_ff    <= '0;
         s8_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ctl_ff    <= s1_ctl_in;
         s2_ctl_ff    <= s1_ctl_ff;
         s3_ctl_ff    <= s2_ctl_ff;
         s4_ctl_ff    <= s3_ctl_ff;
         s5_ctl_ff    <= s4_ctl_ff;
         s6_ctl_ff    <= s5_ctl_ff;
         s7_ctl_ff    <= s6_ctl_ff;
         s8_ctl_ff    <= s7_ctl_ff;
         rsp_valid_ff <= s8_ctl_ff.valid;
      end
   end

   // Data registers need no reset.
   always_ff @(posedge clock) begin
      s1_num_ff     <= s1_num_in;
      s2_num_ff     <= s1_num_ff;
      s2_q10_ff     <= s2_q10_in;
      s3_h_ff       <= s3_h_in;
      s4_h_ff       <= s3_h_ff;
      s4_hi_ff      <= s4_hi_in;
      s5_hi_ff      <= s4_hi_ff;
      s5_lo_ff      <= s5_lo_in;
      s6_hi_ff      <= s5_hi_ff;
      s6_lo_ff      <= s5_lo_ff;
      s6_hi_t_ff    <= s6_hi_t_in;
      s6_lo_h_ff    <= s6_lo_h_in;
      s7_d4_ff      <= s6_hi_t_ff;
      s7_d3_ff      <= s7_d3_in;
      s7_d2_ff      <= s6_lo_h_ff;
      s7_rem_ff     <= s7_rem_in;
      s8_d4_ff      <= s7_d4_ff;
      s8_d3_ff      <= s7_d3_ff;
      s8_d2_ff      <= s7_d2_ff;
      s8_d1_ff      <= s8_d1_in;
      s8_d0_ff      <= s8_d0_in;
      rsp_char_a_ff <= char_a_in;
      rsp_char_b_ff <= char_b_in;
      rsp_char_c_ff <= char_c_in;
      rsp_char_d_ff <= char_d_in;
      rsp_char_e_ff <= char_e_in;
      rsp_char_f_ff <= char_f_in;
      rsp_length_ff <= length_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_char_a = rsp_char_a_ff;
   assign rsp_char_b = rsp_char_b_ff;
   assign rsp_char_c = rsp_char_c_ff;
   assign rsp_char_d = rsp_char_d_ff;
   assign rsp_char_e = rsp_char_e_ff;
   assign rsp_char_f = rsp_char_f_ff;
   assign rsp_length = rsp_length_ff;

   // ------------------------------------------------------------- assertions
   // Every beat taken comes out under rsp_strobe at the end of the pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##9 rsp_strobe)
      else $error("accepted beat did not reach the response port on time");

   // A short string is only ever the mode 0 overflow pattern.
   a_short_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_length == fpdf_pkg::LEN_SHORT) |->
         (rsp_char_a == fpdf_pkg::CH_STAR && rsp_char_b == fpdf_pkg::CH_POINT &&
          rsp_char_f == fpdf_pkg::CH_NUL))
      else $error("short string with unexpected characters");

   // Rounding and clamping keep the hundredths within five digits.
   a_h_range: assert property (@(posedge clock) disable iff (reset)
      s3_ctl_ff.valid |-> (s3_h_ff <= fpdf_pkg::H_MAX))
      else $error("rounded value out of range");

   // The reciprocal divides must leave proper decimal digits.
   a_digits: assert property (@(posedge clock) disable iff (reset)
      s8_ctl_ff.valid |-> (s8_d0_ff <= 4'd9 && s8_d1_ff <= 4'd9 &&
                           s8_d2_ff <= 4'd9 && s8_d3_ff <= 4'd9 &&
                           s8_d4_ff <= 4'd9))
      else $error("digit extraction produced a value above nine");

endmodule

// File: dv/fixed_point_decimal_formatter_tb.sv
// ---------------------------------------------------------------------------
// Fixed-point decimal formatter testbench
// Drives signed milli and unsigned 1/256 words through the formatter, first
// at the edges of both ranges and then at random under several idling
// patterns. Every result beat is compared with a string predicted here.
// ---------------------------------------------------------------------------
module fixed_point_decimal_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The limit lies far above any correct run, so this only trips if the
   // block stops answering.
   localparam int unsigned CYCLE_LIMIT = 200000;
   // The pipeline is nine stages deep; the tail wait is comfortably longer.
   localparam int unsigned TAIL_CYCLES = 30;
   localparam int unsigned MAX_GAP     = 16;

   // One formatted string as it appears on the result ports.
   typedef struct packed {
      logic [fpdf_pkg::CHAR_W-1:0] char_a;
      logic [fpdf_pkg::CHAR_W-1:0] char_b;
      logic [fpdf_pkg::CHAR_W-1:0] char_c;
      logic [fpdf_pkg::CHAR_W-1:0] char_d;
      logic [fpdf_pkg::CHAR_W-1:0] char_e;
      logic [fpdf_pkg::CHAR_W-1:0] char_f;
      logic [fpdf_pkg::LEN_W-1:0]  length;
   } text_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_func = fpdf_pkg::FUNC_MILLI;
   logic [fpdf_pkg::VALUE_W-1:0]  req_value = '0;
   logic                          rsp_strobe;
   logic [fpdf_pkg::CHAR_W-1:0]   rsp_char_a;
   logic [fpdf_pkg::CHAR_W-1:0]   rsp_char_b;
   logic [fpdf_pkg::CHAR_W-1:0]   rsp_char_c;
   logic [fpdf_pkg::CHAR_W-1:0]   rsp_char_d;
   logic [fpdf_pkg::CHAR_W-1:0]   rsp_char_e;
   logic [fpdf_pkg::CHAR_W-1:0]   rsp_char_f;
   logic [fpdf_pkg::LEN_W-1:0]    rsp_length;

   // Strings predicted for beats that have been taken but not yet answered,
   // oldest first.
   text_type    pending_text [$];
   int unsigned error_count     = 0;
   int unsigned cycle_count     = 0;
   int unsigned beats_milli     = 0;
   int unsigned beats_bin8      = 0;
   int unsigned beats_starred   = 0;
   int unsigned results_checked = 0;

   fixed_point_decimal_formatter u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_func   (req_func),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_char_a (rsp_char_a),
      .rsp_char_b (rsp_char_b),
      .rsp_char_c (rsp_char_c),
      .rsp_char_d (rsp_char_d),
      .rsp_char_e (rsp_char_e),
      .rsp_char_f (rsp_char_f),
      .rsp_length (rsp_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic logic [fpdf_pkg::CHAR_W-1:0] ascii_digit(input int unsigned d);
      return fpdf_pkg::CH_ZERO + fpdf_pkg::CHAR_W'(d);
   endfunction

   // Works out the string for one word. In milli mode the magnitude is
   // printed as d.ddd behind a sign or a space; in 1/256 mode the value is
   // scaled to thousandths, rounded to hundredths, printed as ddd.dd with
   // the two leading places blanked while zero. Stars mark overflow.
   function automatic text_type format_value(input logic func,
                                             input logic [fpdf_pkg::VALUE_W-1:0] value);
      text_type                     txt;
      logic [fpdf_pkg::VALUE_W-1:0] mag;
      int unsigned                  scaled;
      int unsigned                  hundredths;
      int unsigned                  hundreds;
      int unsigned                  tens;
      txt = '0;
      if (func == fpdf_pkg::FUNC_MILLI) begin
         mag = value[fpdf_pkg::VALUE_W-1] ? (32'd0 - value) : value;
         if (mag > 32'd9999) begin
            // Out of range either way: four stars around a point, and the
            // sixth character is left as a null.
            txt.char_a = fpdf_pkg::CH_STAR;
            txt.char_b = fpdf_pkg::CH_POINT;
            txt.char_c = fpdf_pkg::CH_STAR;
            txt.char_d = fpdf_pkg::CH_STAR;
            txt.char_e = fpdf_pkg::CH_STAR;
            txt.char_f = fpdf_pkg::CH_NUL;
            txt.length = fpdf_pkg::LEN_SHORT;
         end else begin
            txt.char_a = value[fpdf_pkg::VALUE_W-1] ? fpdf_pkg::CH_MINUS
                                                    : fpdf_pkg::CH_SPACE;
            txt.char_b = ascii_digit(mag / 1000);
            txt.char_c = fpdf_pkg::CH_POINT;
            txt.char_d = ascii_digit((mag / 100) % 10);
            txt.char_e = ascii_digit((mag / 10) % 10);
            txt.char_f = ascii_digit(mag % 10);
            txt.length = fpdf_pkg::LEN_FULL;
         end
      end else if (value > 32'd255999) begin
         txt.char_a = fpdf_pkg::CH_STAR;
         txt.char_b = fpdf_pkg::CH_STAR;
         txt.char_c = fpdf_pkg::CH_STAR;
         txt.char_d = fpdf_pkg::CH_POINT;
         txt.char_e = fpdf_pkg::CH_STAR;
         txt.char_f = fpdf_pkg::CH_STAR;
         txt.length = fpdf_pkg::LEN_FULL;
      end else begin
         // The product stays below 2^28, so 32 bits are ample.
         scaled = (value * 32'd1000) / 32'd256;
         if ((scaled % 10) >= 5) begin
            scaled += 10;
         end
         hundredths = scaled / 10;
         // A carry out of 999.99 is held at 999.99 rather than wrapping.
         if (hundredths > 99999) begin
            hundredths = 99999;
         end
         hundreds = hundredths / 10000;
         tens     = (hundredths / 1000) % 10;
         txt.char_a = (hundreds == 0) ? fpdf_pkg::CH_SPACE : ascii_digit(hundreds);
         txt.char_b = (hundreds == 0 && tens == 0) ? fpdf_pkg::CH_SPACE
                                                   : ascii_digit(tens);
         txt.char_c = ascii_digit((hundredths / 100) % 10);
         txt.char_d = fpdf_pkg::CH_POINT;
         txt.char_e = ascii_digit((hundredths / 10) % 10);
         txt.char_f = ascii_digit(hundredths % 10);
         txt.length = fpdf_pkg::LEN_FULL;
      end
      return txt;
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [fpdf_pkg::CHAR_W-1:0] want,
                              input logic [fpdf_pkg::CHAR_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
         error_count++;
      end
   endtask

   // Every strobed cycle carries one result beat, which must match the oldest
   // prediction. Values are read in the active region of the edge, so they
   // are the ones that were on the ports during the cycle that just ended.
   always @(posedge clock) begin : result_check
      text_type want;
      if (!reset) begin
         if ($isunknown(rsp_strobe)) begin
            $error("rsp_strobe is unknown after reset");
            error_count++;
         end else if (rsp_strobe) begin
            if (pending_text.size() == 0) begin
               $error("result beat arrived with no beat outstanding");
               error_count++;
            end else begin
               want = pending_text.pop_front();
               check_field("char_a", want.char_a, rsp_char_a);
               check_field("char_b", want.char_b, rsp_char_b);
               check_field("char_c", want.char_c, rsp_char_c);
               check_field("char_d", want.char_d, rsp_char_d);
               check_field("char_e", want.char_e, rsp_char_e);
               check_field("char_f", want.char_f, rsp_char_f);
               check_field("length", fpdf_pkg::CHAR_W'(want.length),
                           fpdf_pkg::CHAR_W'(rsp_length));
               results_checked++;
            end
         end
      end
   end

   // Watchdog: ends the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL fixed_point_decimal_formatter");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Presents one beat and holds it until the block takes it. The start line
   // is left high afterwards, so a following beat goes out back to back
   // without start being lowered and raised in the same time step.
   task automatic send_beat(input logic func, input logic [fpdf_pkg::VALUE_W-1:0] value);
      text_type txt;
      req_func  <= func;
      req_value <= value;
      start     <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
      end
      txt = format_value(func, value);
      pending_text.push_back(txt);
      if (func == fpdf_pkg::FUNC_MILLI) begin
         beats_milli++;
      end else begin
         beats_bin8++;
      end
      if (txt.char_a == fpdf_pkg::CH_STAR) begin
         beats_starred++;
      end
   endtask

   // Leaves the request side idle for a random number of cycles, each idle
   // cycle being taken with the given chance in a hundred.
   task automatic idle_gap(input int unsigned pct);
      int unsigned gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < pct) begin
         gap++;
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lowers start and holds off until every outstanding beat has been
   // answered. The loop waits on the clock before it first checks, so start
   // is never driven twice in one step.
   task automatic wait_all_answered();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_text.size() != 0);
   endtask

   // Chooses one random beat. Most words are in range for their format, a
   // good share sit right on the overflow boundaries (and, in 1/256 mode,
   // on the rounding carry past 999.99), some are small, and some are fully
   // random 32-bit words so that every bit of the value is exercised.
   task automatic pick_random_beat(output logic func,
                                   output logic [fpdf_pkg::VALUE_W-1:0] value);
      int unsigned kind;
      int          offset;
      int unsigned mag;
      logic        neg;
      func   = $urandom_range(0, 1) ? fpdf_pkg::FUNC_BIN8 : fpdf_pkg::FUNC_MILLI;
      kind   = $urandom_range(0, 9);
      offset = int'($urandom_range(0, 16)) - 12;
      neg    = 1'($urandom_range(0, 1));
      mag    = 0;
      case (kind)
         0, 1, 2, 3, 4: begin
            mag = (func == fpdf_pkg::FUNC_MILLI) ? $urandom_range(0, 9999)
                                                 : $urandom_range(0, 255999);
         end
         5, 6: begin
            mag = (func == fpdf_pkg::FUNC_MILLI) ? 32'(9999 + offset)
                                                 : 32'(255999 + offset);
         end
         7: begin
            mag = $urandom();
         end
         default: begin
            mag = $urandom_range(0, 700);
         end
      endcase
      value = mag;
      // Fully random words already carry their own sign bit.
      if (func == fpdf_pkg::FUNC_MILLI && kind != 7 && neg) begin
         value = 32'd0 - mag;
      end
   endtask

   task automatic send_random(input int unsigned count, input int unsigned idle_pct);
      logic                         func;
      logic [fpdf_pkg::VALUE_W-1:0] value;
      repeat (count) begin
         pick_random_beat(func, value);
         send_beat(func, value);
         idle_gap(idle_pct);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Signed milli format: zero, a value whose leading zero must stay, both
   // range limits and the first words past them, minus one, and the most
   // positive and most negative words.
   task automatic test_milli_edges();
      logic [fpdf_pkg::VALUE_W-1:0] words [11] = '{
         32'd0, 32'd31, 32'd1234, 32'd5000, 32'd9999, 32'd10000,
         32'hFFFF_FFFF, 32'hFFFF_D8F1, 32'hFFFF_D8F0, 32'h7FFF_FFFF, 32'h8000_0000
      };
      foreach (words[i]) begin
         send_beat(fpdf_pkg::FUNC_MILLI, words[i]);
      end
   endtask

   // Unsigned 1/256 format: zero, one, a word whose thousandths end in
   // exactly five, a round-up into the units, blank and printed leading
   // places, the rounding carry past 999.99, and words past the limit.
   task automatic test_bin8_edges();
      logic [fpdf_pkg::VALUE_W-1:0] words [11] = '{
         32'd0, 32'd1, 32'd4, 32'd255, 32'd2560, 32'd25600,
         32'd255998, 32'd255999, 32'd256000, 32'hFFFF_FFFF, 32'h8000_0000
      };
      foreach (words[i]) begin
         send_beat(fpdf_pkg::FUNC_BIN8, words[i]);
      end
   endtask

   task automatic test_back_to_back();
      send_random(600, 0);
   endtask

   task automatic test_sparse_sender();
      send_random(600, 53);
   endtask

   // Short bursts, each followed by a full drain of the pipeline, so that
   // beats also enter an empty block.
   task automatic test_drain_pauses();
      repeat (6) begin
         send_random(8, 13);
         wait_all_answered();
      end
   endtask

   task automatic test_light_idle();
      send_random(500, 13);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_milli_edges();
      test_bin8_edges();
      test_back_to_back();
      test_sparse_sender();
      test_drain_pauses();
      test_light_idle();

      // Let every outstanding beat come back, then watch a little longer for
      // any stray result beat.
      wait_all_answered();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Formatted %0d signed milli and %0d unsigned 1/256 beats, %0d of them overflow;",
               beats_milli, beats_bin8, beats_starred);
      $display("%0d result beats checked under back-to-back, sparse and drained traffic.",
               results_checked);
      if (error_count == 0 && pending_text.size() == 0) begin
         $display("PASS fixed_point_decimal_formatter");
      end else begin
         $display("FAIL fixed_point_decimal_formatter");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/fpdf_pkg.sv
sv/fixed_point_decimal_formatter.sv
dv/fixed_point_decimal_formatter_tb.sv
